@@ hdl/gsm7pk_pkg.sv @@
// Shared types, constants and the character mapping ROM of the GSM 7-bit packer.
`default_nettype none
package gsm7pk_pkg;

    localparam int PAYLOAD_BYTES = 56;
    localparam int CAP_BITS      = PAYLOAD_BYTES * 8;
    localparam int BPW           = $clog2(CAP_BITS + 1);
    localparam int SEPTET        = 7;
    localparam int STRW          = 2 * SEPTET;
    localparam int ACCW          = 24;
    localparam int CNTW          = BPW - 2;
    localparam int MAX_RES       = 3;
    localparam int QDEPTH        = 2;
    localparam int QAW           = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCW           = $clog2(QDEPTH + 1);

    localparam logic [6:0] ESC_CODE   = 7'h1B;
    localparam logic [6:0] SPACE_CODE = 7'h20;
    localparam logic [7:0] NUL_BYTE   = 8'h00;

    typedef struct packed {
        logic [6:0] code;
        logic       is_ext;
        logic       is_nul;
        logic       eom;
    } t_cls;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       byte_valid;
        logic       last_of_message;
        logic [5:0] byte_count;
    } t_res;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qflags;

    typedef struct packed {
        logic       is_ext;
        logic [6:0] code;
    } t_map;

    // Reverse of the basic and extended alphabet tables. Where a byte sits in
    // both tables the basic entry has the lower index and wins.
    function automatic t_map map_char(input logic [7:0] c);
        t_map m;
        m.is_ext = 1'b0;
        m.code   = SPACE_CODE;
        unique case (c) inside
            [8'h20:8'h23], [8'h25:8'h3F], [8'h41:8'h5A], [8'h61:8'h7A]:
                m.code = c[6:0];
            8'h40: m.code = 7'd0;
            8'hA3: m.code = 7'd1;
            8'h24: m.code = 7'd2;
            8'hA5: m.code = 7'd3;
            8'hE8: m.code = 7'd4;
            8'hE9: m.code = 7'd5;
            8'hF9: m.code = 7'd6;
            8'hEC: m.code = 7'd7;
            8'hF2: m.code = 7'd8;
            8'hC7: m.code = 7'd9;
            8'h0A: m.code = 7'd10;
            8'hD8: m.code = 7'd11;
            8'hF8: m.code = 7'd12;
            8'h0D: m.code = 7'd13;
            8'hC5: m.code = 7'd14;
            8'hE5: m.code = 7'd15;
            8'h80: m.code = 7'd16;
            8'h5F: m.code = 7'd17;
            8'h81: m.code = 7'd18;
            8'h82: m.code = 7'd19;
            8'h83: m.code = 7'd20;
            8'h84: m.code = 7'd21;
            8'h85: m.code = 7'd22;
            8'h86: m.code = 7'd23;
            8'h87: m.code = 7'd24;
            8'h88: m.code = 7'd25;
            8'h89: m.code = 7'd26;
            8'h1B: m.code = 7'd27;
            8'hC6: m.code = 7'd28;
            8'hE6: m.code = 7'd29;
            8'hDF: m.code = 7'd30;
            8'hC9: m.code = 7'd31;
            8'hA4: m.code = 7'h24;
            8'hA1: m.code = 7'h40;
            8'hC4: m.code = 7'h5B;
            8'hD6: m.code = 7'h5C;
            8'hD1: m.code = 7'h5D;
            8'hDC: m.code = 7'h5E;
            8'hA7: m.code = 7'h5F;
            8'hBF: m.code = 7'h60;
            8'hE4: m.code = 7'h7B;
            8'hF6: m.code = 7'h7C;
            8'hF1: m.code = 7'h7D;
            8'hFC: m.code = 7'h7E;
            8'hE0: m.code = 7'h7F;
            8'h0C: begin m.is_ext = 1'b1; m.code = 7'd10;  end
            8'h5E: begin m.is_ext = 1'b1; m.code = 7'd20;  end
            8'h7B: begin m.is_ext = 1'b1; m.code = 7'd40;  end
            8'h7D: begin m.is_ext = 1'b1; m.code = 7'd41;  end
            8'h5B: begin m.is_ext = 1'b1; m.code = 7'd44;  end
            8'h5C: begin m.is_ext = 1'b1; m.code = 7'd47;  end
            8'h7E: begin m.is_ext = 1'b1; m.code = 7'd61;  end
            8'h5D: begin m.is_ext = 1'b1; m.code = 7'd62;  end
            8'h7C: begin m.is_ext = 1'b1; m.code = 7'd64;  end
            default: m.code = SPACE_CODE;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

@@ hdl/gsm7pk_in_if.sv @@
// Valid/ready channel carrying one text character item.
`default_nettype none
interface gsm7pk_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       end_of_message;

    modport source(output valid, char_byte, end_of_message, input ready);
    modport sink(input valid, char_byte, end_of_message, output ready);
endinterface
`default_nettype wire

@@ hdl/gsm7pk_out_if.sv @@
// Valid/ready channel carrying one packed octet item.
`default_nettype none
interface gsm7pk_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] packed_byte;
    logic       byte_valid;
    logic       last_of_message;
    logic [5:0] byte_count;

    modport source(output valid, packed_byte, byte_valid, last_of_message, byte_count,
                   input ready);
    modport sink(input valid, packed_byte, byte_valid, last_of_message, byte_count,
                 output ready);
endinterface
`default_nettype wire

@@ hdl/gsm7pk_front.sv @@
// Front stage: accepts characters, looks up the septet code and classifies the item.
`default_nettype none
module gsm7pk_front (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    gsm7pk_in_if.sink              i_in,
    input  gsm7pk_pkg::t_qflags    i_qflags,
    output logic                   o_push,
    output gsm7pk_pkg::t_cls       o_cls
);

    logic              r_valid;
    gsm7pk_pkg::t_cls  r_cls;
    gsm7pk_pkg::t_cls  n_cls;
    gsm7pk_pkg::t_map  w_map;
    logic              w_accept;

    assign o_push     = r_valid && !i_qflags.full;
    assign i_in.ready = !r_valid || !i_qflags.full;
    assign w_accept   = i_in.valid && i_in.ready;

    always_comb begin
        w_map        = gsm7pk_pkg::map_char(i_in.char_byte);
        n_cls.code   = w_map.code;
        n_cls.is_ext = w_map.is_ext;
        n_cls.is_nul = (i_in.char_byte == gsm7pk_pkg::NUL_BYTE);
        n_cls.eom    = i_in.end_of_message;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cls <= n_cls;
        end
    end

    assign o_cls = r_cls;

endmodule
`default_nettype wire

@@ hdl/gsm7pk_queue.sv @@
// Short queue of classified items between the front and back stages.
`default_nettype none
module gsm7pk_queue (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_push,
    input  gsm7pk_pkg::t_cls       i_cls,
    input  wire                    i_pop,
    output gsm7pk_pkg::t_cls       o_head,
    output gsm7pk_pkg::t_qflags    o_qflags
);

    gsm7pk_pkg::t_cls                r_mem [gsm7pk_pkg::QDEPTH];
    logic [gsm7pk_pkg::QAW-1:0]      r_wr;
    logic [gsm7pk_pkg::QAW-1:0]      r_rd;
    logic [gsm7pk_pkg::QCW-1:0]      r_cnt;

    function automatic logic [gsm7pk_pkg::QAW-1:0] bump(input logic [gsm7pk_pkg::QAW-1:0] p);
        if (p == gsm7pk_pkg::QAW'(gsm7pk_pkg::QDEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    assign o_qflags.full  = (r_cnt == gsm7pk_pkg::QCW'(gsm7pk_pkg::QDEPTH));
    assign o_qflags.empty = (r_cnt == '0);
    assign o_head         = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= bump(r_wr);
            end
            if (i_pop) begin
                r_rd <= bump(r_rd);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cls;
        end
    end

endmodule
`default_nettype wire

@@ hdl/gsm7pk_back.sv @@
// Back stage: packs septets into octets, handles capacity and end of message,
// and streams the results of each item out of a small result buffer.
`default_nettype none
module gsm7pk_back (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  gsm7pk_pkg::t_cls       i_head,
    input  gsm7pk_pkg::t_qflags    i_qflags,
    output logic                   o_pop,
    gsm7pk_out_if.source           o_out
);

    localparam int BPW  = gsm7pk_pkg::BPW;
    localparam int CW   = BPW + 5;
    localparam int STRW = gsm7pk_pkg::STRW;
    localparam int ACCW = gsm7pk_pkg::ACCW;
    localparam int CNTW = gsm7pk_pkg::CNTW;
    localparam logic [BPW-1:0] CAP_V = BPW'(gsm7pk_pkg::CAP_BITS);

    logic [6:0]       r_pend;
    logic [BPW-1:0]   r_bitpos;
    logic             r_ended;
    logic [1:0]       r_left;
    gsm7pk_pkg::t_res r_res [gsm7pk_pkg::MAX_RES];

    logic             w_take;
    logic             w_active;
    logic [4:0]       w_nb_raw;
    logic [4:0]       w_nb;
    logic [BPW-1:0]   w_room;
    logic [STRW-1:0]  w_stream;
    logic [STRW-1:0]  w_stream_m;
    logic [2:0]       w_off;
    logic [ACCW-1:0]  w_acc;
    logic [4:0]       w_total;
    logic [1:0]       w_nfull;
    logic [2:0]       w_rem;
    logic [6:0]       n_pend;
    logic [BPW-1:0]   n_bitpos;
    logic             n_ended;
    logic [CNTW-1:0]  w_count;
    logic [1:0]       n_left;
    gsm7pk_pkg::t_res w_res [gsm7pk_pkg::MAX_RES];

    assign w_take = o_out.valid && o_out.ready;
    assign o_pop  = !i_qflags.empty && ((r_left == 2'd0) || ((r_left == 2'd1) && w_take));

    always_comb begin
        w_active = !r_ended && !i_head.is_nul;
        w_nb_raw = !w_active ? 5'd0 :
                   (i_head.is_ext ? 5'(2 * gsm7pk_pkg::SEPTET) : 5'(gsm7pk_pkg::SEPTET));
        w_room   = CAP_V - r_bitpos;
        w_nb     = (CW'(w_room) < CW'(w_nb_raw)) ? 5'(w_room) : w_nb_raw;

        // The escape code goes out first, so it takes the low septet of the stream.
        w_stream   = i_head.is_ext ? {i_head.code, gsm7pk_pkg::ESC_CODE}
                                   : {7'd0, i_head.code};
        w_stream_m = w_stream & ~({STRW{1'b1}} << w_nb);

        w_off   = r_bitpos[2:0];
        w_acc   = ACCW'(r_pend) | (ACCW'(w_stream_m) << w_off);
        w_total = 5'(w_off) + w_nb;
        w_nfull = w_total[4:3];
        w_rem   = w_total[2:0];

        case (w_nfull)
            2'd0:    n_pend = w_acc[6:0];
            2'd1:    n_pend = w_acc[14:8];
            default: n_pend = w_acc[22:16];
        endcase

        n_bitpos = r_bitpos + BPW'(w_nb);
        n_ended  = r_ended || i_head.is_nul || (n_bitpos >= CAP_V);
        w_count  = CNTW'(n_bitpos >> 3) + CNTW'(n_bitpos[2:0] != 3'd0);

        for (int k = 0; k < gsm7pk_pkg::MAX_RES; k++) begin
            w_res[k].packed_byte     = w_acc[8*k +: 8];
            w_res[k].byte_valid      = 1'b1;
            w_res[k].last_of_message = 1'b0;
            w_res[k].byte_count      = 6'd0;
        end
        n_left = w_nfull;

        if (i_head.eom) begin
            if (w_rem != 3'd0) begin
                w_res[w_nfull].packed_byte     = {1'b0, n_pend};
                w_res[w_nfull].last_of_message = 1'b1;
                w_res[w_nfull].byte_count      = 6'(w_count);
                n_left = w_nfull + 2'd1;
            end else if (w_nfull != 2'd0) begin
                w_res[w_nfull - 2'd1].last_of_message = 1'b1;
                w_res[w_nfull - 2'd1].byte_count      = 6'(w_count);
            end else begin
                // Nothing left to send: a bare end marker closes the message.
                w_res[0].packed_byte     = 8'd0;
                w_res[0].byte_valid      = 1'b0;
                w_res[0].last_of_message = 1'b1;
                w_res[0].byte_count      = 6'(w_count);
                n_left = 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= 2'd0;
            r_pend   <= 7'd0;
            r_bitpos <= '0;
            r_ended  <= 1'b0;
        end else if (o_pop) begin
            r_left <= n_left;
            if (i_head.eom) begin
                r_pend   <= 7'd0;
                r_bitpos <= '0;
                r_ended  <= 1'b0;
            end else begin
                r_pend   <= n_pend;
                r_bitpos <= n_bitpos;
                r_ended  <= n_ended;
            end
        end else if (w_take) begin
            r_left <= r_left - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= w_res;
        end else if (w_take) begin
            for (int k = 0; k < gsm7pk_pkg::MAX_RES - 1; k++) begin
                r_res[k] <= r_res[k + 1];
            end
        end
    end

    assign o_out.valid           = (r_left != 2'd0);
    assign o_out.packed_byte     = r_res[0].packed_byte;
    assign o_out.byte_valid      = r_res[0].byte_valid;
    assign o_out.last_of_message = r_res[0].last_of_message;
    assign o_out.byte_count      = r_res[0].byte_count;

    a_bitpos_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bitpos <= CAP_V)
        else $error("bit position beyond payload capacity");

    a_pend_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend >> r_bitpos[2:0]) == 7'd0)
        else $error("stray bits above the fill point of the partial octet");

    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.byte_valid) |-> o_out.last_of_message)
        else $error("end marker without last_of_message");

    a_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= 2'(gsm7pk_pkg::MAX_RES))
        else $error("result buffer overfilled");

    a_count_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.last_of_message) |-> (o_out.byte_count == 6'd0))
        else $error("byte count on a result that does not end the message");

endmodule
`default_nettype wire

@@ hdl/gsm7_septet_packer_core.sv @@
// Top level of the GSM 7-bit septet packer.
//
//   channel   direction  payload
//   i_in      in         char_byte[7:0], end_of_message
//   o_out     out        packed_byte[7:0], byte_valid, last_of_message, byte_count[5:0]
//
// A character enters every cycle while the queue has room; the back stage takes
// the next item once the last result of the previous one is taken, and sends
// one result per cycle on o_out while o_out is ready, at most three per item.
// An item reaches o_out through the front register, the queue and the result buffer.
// Reset is synchronous and clears the queue, the result buffer and the packing
// state. A stall on o_out fills the result buffer, then the queue, then i_in.
`default_nettype none
module gsm7_septet_packer_core (
    input  wire            i_clk,
    input  wire            i_rst_n,
    gsm7pk_in_if.sink      i_in,
    gsm7pk_out_if.source   o_out
);

    logic                   w_push;
    logic                   w_pop;
    gsm7pk_pkg::t_cls       w_cls;
    gsm7pk_pkg::t_cls       w_head;
    gsm7pk_pkg::t_qflags    w_qflags;

    gsm7pk_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_qflags (w_qflags),
        .o_push   (w_push),
        .o_cls    (w_cls)
    );

    gsm7pk_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cls    (w_cls),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_qflags (w_qflags)
    );

    gsm7pk_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_qflags (w_qflags),
        .o_pop    (w_pop),
        .o_out    (o_out)
    );

endmodule
`default_nettype wire

@@ test/gsm7pk_octet_checker.sv @@
// Checker for the GSM 7-bit packer: predicts the packed octets of each item and compares them.
module gsm7pk_octet_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    gsm7pk_in_if  i_char_mon,
    gsm7pk_out_if i_oct_mon,
    output int    o_mismatches,
    output int    o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP_BITS = gsm7pk_pkg::PAYLOAD_BYTES * 8;

    // Basic alphabet, one byte per code, code 0 in the top byte.
    localparam logic [1023:0] BASIC_GLYPHS = {
        128'h40A324A5_E8E9F9EC_F2C70AD8_F80DC5E5,
        128'h805F8182_83848586_8788891B_C6E6DFC9,
        128'h20212223_A4252627_28292A2B_2C2D2E2F,
        128'h30313233_34353637_38393A3B_3C3D3E3F,
        128'hA1414243_44454647_48494A4B_4C4D4E4F,
        128'h50515253_54555657_58595AC4_D6D1DCA7,
        128'hBF616263_64656667_68696A6B_6C6D6E6F,
        128'h70717273_74757677_78797AE4_F6F1FCE0
    };

    // Extended alphabet as {code, byte} pairs in rising code order.
    localparam logic [175:0] EXT_PAIRS = {
        16'h0A0C, 16'h145E, 16'h287B, 16'h297D, 16'h2C5B, 16'h2F5C,
        16'h3D7E, 16'h3E5D, 16'h407C, 16'h7520, 16'h76A4
    };

    logic [7:0]        septet_acc  = '0;
    int                bits_packed = 0;
    logic              msg_closed  = 1'b0;
    gsm7pk_pkg::t_res  item_octets [$];
    gsm7pk_pkg::t_res  octets_due [$];

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
    end

    task automatic report(input string msg);
        $display("[%0t] octet check: %s", $realtime, msg);
        o_mismatches = o_mismatches + 1;
    endtask

    function automatic gsm7pk_pkg::t_res make_octet(input logic [7:0] b, input logic v,
                                                    input logic last, input logic [5:0] cnt);
        gsm7pk_pkg::t_res r;
        r.packed_byte     = b;
        r.byte_valid      = v;
        r.last_of_message = last;
        r.byte_count      = cnt;
        return r;
    endfunction

    // The lowest code wins when a byte sits in both alphabets; basic wins a tie.
    task automatic map_glyph(input logic [7:0] c, output logic ext, output logic [6:0] code);
        int basic_idx;
        int ext_code;
        basic_idx = 128;
        ext_code  = 128;
        for (int i = 127; i >= 0; i--)
            if (BASIC_GLYPHS[(127 - i) * 8 +: 8] == c) basic_idx = i;
        for (int j = 10; j >= 0; j--)
            if (EXT_PAIRS[(10 - j) * 16 +: 8] == c) ext_code = EXT_PAIRS[(10 - j) * 16 + 8 +: 8];
        if (basic_idx < 128 && basic_idx <= ext_code) begin
            ext  = 1'b0;
            code = 7'(basic_idx);
        end else if (ext_code < 128) begin
            ext  = 1'b1;
            code = 7'(ext_code);
        end else begin
            ext  = 1'b0;
            code = gsm7pk_pkg::SPACE_CODE;
        end
    endtask

    task automatic push_septet(input logic [6:0] code);
        for (int b = 0; b < 7; b++) begin
            if (bits_packed >= CAP_BITS) return;
            if (code[b]) septet_acc[bits_packed % 8] = 1'b1;
            bits_packed++;
            if (bits_packed % 8 == 0) begin
                item_octets.push_back(make_octet(septet_acc, 1'b1, 1'b0, 6'd0));
                septet_acc = '0;
            end
        end
    endtask

    task automatic pack_char(input logic [7:0] c, input logic eom);
        logic       ext;
        logic [6:0] code;
        logic [5:0] total;
        int         tail;
        item_octets.delete();
        if (!msg_closed) begin
            if (c == gsm7pk_pkg::NUL_BYTE) begin
                msg_closed = 1'b1;
            end else begin
                map_glyph(c, ext, code);
                if (ext) push_septet(gsm7pk_pkg::ESC_CODE);
                push_septet(code);
                if (bits_packed >= CAP_BITS) msg_closed = 1'b1;
            end
        end
        if (eom) begin
            total = 6'((bits_packed + 7) / 8);
            if (bits_packed % 8 != 0) begin
                item_octets.push_back(make_octet(septet_acc, 1'b1, 1'b1, total));
            end else if (item_octets.size() > 0) begin
                // The octet that closed this item also closes the message.
                tail = item_octets.size() - 1;
                item_octets[tail].last_of_message = 1'b1;
                item_octets[tail].byte_count      = total;
            end else begin
                item_octets.push_back(make_octet(8'h00, 1'b0, 1'b1, total));
            end
            septet_acc  = '0;
            bits_packed = 0;
            msg_closed  = 1'b0;
        end
        foreach (item_octets[k]) octets_due.push_back(item_octets[k]);
    endtask

    task automatic check_octet(input gsm7pk_pkg::t_res got);
        gsm7pk_pkg::t_res want;
        if (octets_due.size() == 0) begin
            report($sformatf("unexpected octet %02h valid %0b last %0b count %0d",
                             got.packed_byte, got.byte_valid, got.last_of_message,
                             got.byte_count));
            return;
        end
        want = octets_due.pop_front();
        if (got.packed_byte !== want.packed_byte)
            report($sformatf("packed_byte %02h, expected %02h",
                             got.packed_byte, want.packed_byte));
        if (got.byte_valid !== want.byte_valid)
            report($sformatf("byte_valid %0b, expected %0b", got.byte_valid, want.byte_valid));
        if (got.last_of_message !== want.last_of_message)
            report($sformatf("last_of_message %0b, expected %0b",
                             got.last_of_message, want.last_of_message));
        if (got.byte_count !== want.byte_count)
            report($sformatf("byte_count %0d, expected %0d", got.byte_count, want.byte_count));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            septet_acc  = '0;
            bits_packed = 0;
            msg_closed  = 1'b0;
            octets_due.delete();
        end else begin
            if (i_char_mon.valid && i_char_mon.ready)
                pack_char(i_char_mon.char_byte, i_char_mon.end_of_message);
            if (i_oct_mon.valid && i_oct_mon.ready)
                check_octet(make_octet(i_oct_mon.packed_byte, i_oct_mon.byte_valid,
                                       i_oct_mon.last_of_message, i_oct_mon.byte_count));
        end
        o_outstanding <= octets_due.size();
    end

endmodule

@@ test/gsm7_septet_packer_core_tb.sv @@
// Testbench top for the GSM 7-bit packer: text stimulus, handshake pacing and the verdict.
module gsm7_septet_packer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // A 13 percent receiver makes long stalls geometric; this bound is never hit by a live block.
    localparam int WATCHDOG_LIMIT = 2000;

    // Extended-alphabet bytes and a few bytes on the edges of the mapping.
    localparam logic [71:0] EXT_BYTES  = 72'h0C5E7B7D5B5C7E5D7C;
    localparam logic [63:0] EDGE_BYTES = 64'h1B20A440E0FF0A0D;

    logic i_clk;
    logic i_rst_n;
    int   tx_idle_pct = 18;
    int   rx_idle_pct = 87;
    int   mismatches;
    int   outstanding;
    int   quiet_cycles = 0;

    gsm7pk_in_if  in_ch ();
    gsm7pk_out_if out_ch ();

    gsm7_septet_packer_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    gsm7pk_octet_checker chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_char_mon    (in_ch),
        .i_oct_mon     (out_ch),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_char(input logic [7:0] c, input logic eom);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.char_byte      <= c;
        in_ch.end_of_message <= eom;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] pick_char(input logic allow_nul);
        int roll;
        roll = $urandom_range(99);
        if (allow_nul && roll < 4) return 8'h00;
        if (roll < 30) return EXT_BYTES[$urandom_range(8) * 8 +: 8];
        if (roll < 40) return EDGE_BYTES[$urandom_range(7) * 8 +: 8];
        return 8'($urandom_range(255, 1));
    endfunction

    task automatic send_text(input int n_chars, input logic allow_nul);
        for (int k = 0; k < n_chars; k++)
            send_char(pick_char(allow_nul), k == n_chars - 1);
    endtask

    initial begin
        int sent;
        int len;
        in_ch.valid          = 1'b0;
        in_ch.char_byte      = 8'h00;
        in_ch.end_of_message = 1'b0;
        i_rst_n              = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty message, then a one-character message.
        send_char(8'h00, 1'b1);
        send_char(8'h41, 1'b1);
        // Code extremes, both escapes, bytes in both alphabets, unknown byte, escape byte.
        send_char(8'h40, 1'b0);
        send_char(8'hE0, 1'b0);
        send_char(8'h0C, 1'b0);
        send_char(8'h7C, 1'b0);
        send_char(8'hA4, 1'b0);
        send_char(8'h20, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h1B, 1'b0);
        send_char(8'h5E, 1'b1);
        // A NUL ends the text early; the characters after it are dropped.
        send_char(8'h48, 1'b0);
        send_char(8'h49, 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'h4A, 1'b1);
        // Eight characters fill seven octets exactly, so the closing NUL gives an end marker.
        send_char(8'h48, 1'b0);
        send_char(8'h45, 1'b0);
        send_char(8'h4C, 1'b0);
        send_char(8'h4C, 1'b0);
        send_char(8'h4F, 1'b0);
        send_char(8'h31, 1'b0);
        send_char(8'h32, 1'b0);
        send_char(8'h33, 1'b0);
        send_char(8'h00, 1'b1);

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    tx_idle_pct = 18;
                    rx_idle_pct = 87;
                end
                1: begin
                    tx_idle_pct = 87;
                    rx_idle_pct = 18;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            // One message long enough to run into the payload capacity.
            send_text($urandom_range(72, 62), 1'b0);
            sent = 0;
            while (sent < 40) begin
                len = $urandom_range(12);
                if (len == 0) begin
                    send_char(8'h00, 1'b1);
                    sent++;
                end else begin
                    send_text(len, 1'b1);
                    sent += len;
                end
            end
        end
        in_ch.valid <= 1'b0;

        while (outstanding != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/gsm7pk_pkg.sv
hdl/gsm7pk_in_if.sv
hdl/gsm7pk_out_if.sv
hdl/gsm7pk_front.sv
hdl/gsm7pk_queue.sv
hdl/gsm7pk_back.sv
hdl/gsm7_septet_packer_core.sv
test/gsm7pk_octet_checker.sv
test/gsm7_septet_packer_core_tb.sv
